/* design/pst_pkg.sv */
// Package with the shared types and constants of the scanline mode timing block.
package pst_pkg;

    // Timing constants, in machine cycles and lines.
    localparam logic [6:0] LINE_DOTS         = 7'd114;
    localparam logic [6:0] SCAN_END          = 7'd20;
    localparam logic [6:0] DRAW_END          = 7'd63;
    localparam logic [6:0] DRAW_DOT          = 7'd21;
    localparam logic [7:0] LAST_LINE         = 8'd153;
    localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;

    // Mode codes.
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SCAN   = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HBLANK_IRQ_EN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VBLANK_STAT_EN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_IRQ_EN     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_IRQ_EN  = 3'd4;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0] line_compare;
        logic       hblank_irq_enable;
        logic       vblank_stat_irq_enable;
        logic       scan_irq_enable;
        logic       compare_irq_enable;
    } cfg_t;

    // One result word.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  line;
        logic [6:0]  dot;
        logic        match_flag;
        logic        stat_irq;
        logic        vblank_irq;
        logic        draw_line;
        logic [15:0] frames;
    } res_t;

endpackage

/* design/pst_if.sv */
// Channel interfaces of the scanline mode timing block.

// Tick channel: one word per machine-cycle step.
interface pst_tick_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink (input valid, input advance, output ready);
endinterface

// Result channel: one word per accepted tick.
interface pst_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  line;
    logic [6:0]  dot;
    logic        match_flag;
    logic        stat_irq;
    logic        vblank_irq;
    logic        draw_line;
    logic [15:0] frames;

    modport source (output valid, output mode, output line, output dot, output match_flag,
                    output stat_irq, output vblank_irq, output draw_line, output frames,
                    input ready);
    modport sink (input valid, input mode, input line, input dot, input match_flag,
                  input stat_irq, input vblank_irq, input draw_line, input frames,
                  output ready);
endinterface

// Configuration write channel.
interface pst_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* design/pst_cfg_regs.sv */
// Configuration register file of the scanline mode timing block.
module pst_cfg_regs
    import pst_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; writes beyond the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_LINE_COMPARE:   cfg_next.line_compare           = wr_data;
                REG_HBLANK_IRQ_EN:  cfg_next.hblank_irq_enable      = wr_data[0];
                REG_VBLANK_STAT_EN: cfg_next.vblank_stat_irq_enable = wr_data[0];
                REG_SCAN_IRQ_EN:    cfg_next.scan_irq_enable        = wr_data[0];
                REG_COMPARE_IRQ_EN: cfg_next.compare_irq_enable     = wr_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/pst_timing.sv */
// Dot, line and mode state of the picture unit with its one-step update logic.
module pst_timing
    import pst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step_en,
    input  logic advance,
    input  cfg_t cfg,
    output res_t res
);

    logic [6:0]  dot_reg,   dot_next;
    logic [7:0]  line_reg,  line_next;
    logic [1:0]  mode_reg,  mode_next;
    logic        sreq_reg,  sreq_next;
    logic        flag_reg,  flag_next;
    logic [15:0] frame_reg, frame_next;

    logic [6:0] dot_inc;
    logic       line_end;
    logic       entry_try;
    logic       stat_pulse;
    logic       vblank_pulse;
    logic       draw_pulse;

    assign dot_inc = 7'(dot_reg + 7'd1);

    // Next state for one step: mode change, line end, interrupt gating, compare.
    always_comb
    begin
        dot_next     = dot_reg;
        line_next    = line_reg;
        mode_next    = mode_reg;
        sreq_next    = sreq_reg;
        flag_next    = flag_reg;
        frame_next   = frame_reg;
        line_end     = 1'b0;
        entry_try    = 1'b0;
        stat_pulse   = 1'b0;
        vblank_pulse = 1'b0;
        draw_pulse   = 1'b0;

        if (advance)
        begin
            dot_next = dot_inc;
            case (mode_reg)
                MODE_HBLANK, MODE_VBLANK:
                begin
                    line_end = (dot_inc == LINE_DOTS);
                end
                MODE_SCAN:
                begin
                    if (dot_inc == SCAN_END)
                    begin
                        mode_next = MODE_DRAW;
                    end
                end
                default:
                begin
                    if (dot_inc == DRAW_END)
                    begin
                        mode_next = MODE_HBLANK;
                        entry_try = cfg.hblank_irq_enable;
                    end
                    else if (dot_inc == DRAW_DOT)
                    begin
                        draw_pulse = 1'b1;
                    end
                end
            endcase

            // Line wrap: next line, frame count and the mode that a new line opens with.
            if (line_end)
            begin
                dot_next = '0;
                if (line_reg == LAST_LINE)
                begin
                    line_next  = '0;
                    mode_next  = MODE_SCAN;
                    entry_try  = cfg.scan_irq_enable;
                    frame_next = 16'(frame_reg + 16'd1);
                end
                else if (line_reg == LAST_VISIBLE_LINE)
                begin
                    line_next    = FIRST_VBLANK_LINE;
                    mode_next    = MODE_VBLANK;
                    entry_try    = cfg.vblank_stat_irq_enable;
                    vblank_pulse = 1'b1;
                end
                else
                begin
                    line_next = 8'(line_reg + 8'd1);
                    if (mode_reg == MODE_HBLANK)
                    begin
                        mode_next = MODE_SCAN;
                        entry_try = cfg.scan_irq_enable;
                    end
                end
            end

            // STAT request on mode entry, at most once per line.
            if (entry_try && !sreq_next)
            begin
                sreq_next  = 1'b1;
                stat_pulse = 1'b1;
            end

            // Line compare after the new line is in place.
            if (line_end)
            begin
                if ((line_next == cfg.line_compare) && cfg.compare_irq_enable)
                begin
                    if (!sreq_next)
                    begin
                        sreq_next  = 1'b1;
                        stat_pulse = 1'b1;
                    end
                    flag_next = 1'b1;
                end
                else
                begin
                    flag_next = 1'b0;
                    sreq_next = 1'b0;
                end
            end
        end
    end

    // State registers, updated once per accepted step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= '0;
            line_reg  <= '0;
            mode_reg  <= MODE_SCAN;
            sreq_reg  <= 1'b0;
            flag_reg  <= 1'b0;
            frame_reg <= '0;
        end
        else if (step_en)
        begin
            dot_reg   <= dot_next;
            line_reg  <= line_next;
            mode_reg  <= mode_next;
            sreq_reg  <= sreq_next;
            flag_reg  <= flag_next;
            frame_reg <= frame_next;
        end
    end

    // Result word of this step.
    always_comb
    begin
        res.mode       = mode_next;
        res.line       = line_next;
        res.dot        = dot_next;
        res.match_flag = flag_next;
        res.stat_irq   = stat_pulse;
        res.vblank_irq = vblank_pulse;
        res.draw_line  = draw_pulse;
        res.frames     = frame_next;
    end

`ifndef SYNTHESIS
    // The dot position never reaches the line length.
    assert property (@(posedge clk) disable iff (!rst_n) dot_reg < LINE_DOTS)
        else $error("dot position out of range");

    // Vblank mode exactly on the lines after the last visible one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_VBLANK) == (line_reg > LAST_VISIBLE_LINE))
        else $error("mode and line disagree on vblank");

    // The vblank pulse opens the first vblank line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.vblank_irq) |-> (res.line == FIRST_VBLANK_LINE && res.dot == 7'd0))
        else $error("vblank pulse at the wrong place");

    // An idle step leaves the position untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !advance) |=> ($stable(dot_reg) && $stable(line_reg) && $stable(mode_reg)))
        else $error("idle step changed the position");
`endif

endmodule

/* design/ppu_scanline_mode_timing_core.sv */
// Top level of the scanline mode timing block: channels, input and result registers.
//
// Use: each word on the tick channel is one step; advance = 1 moves the unit on by one
// machine cycle, advance = 0 repeats the current state with no pulses. For every tick
// word exactly one result word comes out on the result channel, in order, carrying the
// mode, line, dot, stored compare flag, the STAT, vblank and draw pulses of that step
// and the frame count.
// Path: a tick word accepted on the tick channel is held in the input register and then
// in the result register, from which it is shown on the result channel.
// Throughput: one word per cycle while the result channel takes its words; the dot, line
// and mode registers between the two stages are updated once per moving word.
// Configuration: the cfg channel is always ready; index 0 is the compare line, 1 to 4
// are the hblank, vblank, scan and compare STAT enables. Other indexes are ignored.
// Reset: line 0, dot 0, scan mode, flags and frame count cleared, enables off, both
// channels empty.
// Stall: while the result word is not taken, the input register still takes one more
// word; then tick.ready falls until the result moves on. No word is lost or repeated.
module ppu_scanline_mode_timing_core
    import pst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pst_tick_if.sink     tick,
    pst_result_if.source result,
    pst_cfg_if.sink      cfg
);

    cfg_t cfg_regs;
    res_t step_res;
    res_t res_reg;

    logic s1_valid_reg;
    logic s1_advance_reg;
    logic out_valid_reg;
    logic s1_move;
    logic tick_fire;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    pst_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_regs)
    );

    // Handshake: the stage moves when the result register is free or being emptied.
    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !s1_valid_reg || s1_move;
    assign tick_fire  = tick.valid && tick.ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            s1_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            s1_advance_reg <= tick.advance;
        end
    end

    // State update logic.
    pst_timing u_timing (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_move),
        .advance (s1_advance_reg),
        .cfg     (cfg_regs),
        .res     (step_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_reg <= step_res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.mode       = res_reg.mode;
    assign result.line       = res_reg.line;
    assign result.dot        = res_reg.dot;
    assign result.match_flag = res_reg.match_flag;
    assign result.stat_irq   = res_reg.stat_irq;
    assign result.vblank_irq = res_reg.vblank_irq;
    assign result.draw_line  = res_reg.draw_line;
    assign result.frames     = res_reg.frames;

endmodule
